// ===== rtl/cgs_pkg.sv =====
// Shared types and constants of the crossing gate sequencer.
package cgs_pkg;

   // Init delay counter width and register width
   localparam int CountWidth = 20;
   localparam int DelayWidth = 20;
   localparam int CmpWidth = (CountWidth > DelayWidth) ? CountWidth : DelayWidth;
   localparam logic [DelayWidth-1:0] DelayReset = DelayWidth'(3000);

   // Configuration port
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam logic CsrIdxInitDelay = 1'b0;

   // Lamp colors
   localparam logic [1:0] LedGreen  = 2'd0;
   localparam logic [1:0] LedOrange = 2'd1;
   localparam logic [1:0] LedRed    = 2'd2;

   // Gate commands
   localparam logic [1:0] GateNone  = 2'd0;
   localparam logic [1:0] GateClose = 2'd1;
   localparam logic [1:0] GateOpen  = 2'd2;

   // Entry horn codes
   localparam logic [1:0] HornNone    = 2'd0;
   localparam logic [1:0] HornConfirm = 2'd1;
   localparam logic [1:0] HornWarning = 2'd2;

   // Exit horn codes
   localparam logic [1:0] PassNone = 2'd0;
   localparam logic [1:0] PassAtA  = 2'd1;
   localparam logic [1:0] PassAtB  = 2'd2;

   typedef struct packed {
      logic switch_pushed;
      logic train_at_entry;
      logic train_in_crossing;
      logic gate_is_closed;
      logic gate_is_opened;
   } req_type;

   typedef struct packed {
      logic [2:0] mode_now;
      logic       entered;
      logic [1:0] led_color;
      logic       reinit_sensors;
      logic [1:0] gate_command;
      logic [1:0] entry_horn;
      logic [1:0] exit_horn;
      logic       calibrate;
   } rsp_type;

endpackage

// ===== rtl/cgs_csr.sv =====
// Configuration register file: holds the init delay.
module cgs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cgs_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [cgs_pkg::CsrDataWidth-1:0] pwdata,
   output logic [cgs_pkg::CsrDataWidth-1:0] prdata,
   output logic                             pready,
   output logic [cgs_pkg::DelayWidth-1:0]   init_delay
);

   logic [cgs_pkg::DelayWidth-1:0] init_delay_ff;
   logic [cgs_pkg::DelayWidth-1:0] init_delay_in;
   logic                           wr_hit;

   // Decode a completed write to the delay register
   assign wr_hit = psel && penable && pwrite && pready
                   && (paddr[cgs_pkg::CsrAddrWidth-1] == cgs_pkg::CsrIdxInitDelay);

   always_comb begin
      init_delay_in = init_delay_ff;
      if (wr_hit) begin
         init_delay_in = pwdata[cgs_pkg::DelayWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_delay_ff <= cgs_pkg::DelayReset;
      end else begin
         init_delay_ff <= init_delay_in;
      end
   end

   // Return the register on reads; no wait states
   always_comb begin
      prdata = '0;
      if (paddr[cgs_pkg::CsrAddrWidth-1] == cgs_pkg::CsrIdxInitDelay) begin
         prdata = cgs_pkg::CsrDataWidth'(init_delay_ff);
      end
   end

   assign pready     = 1'b1;
   assign init_delay = init_delay_ff;

endmodule

// ===== rtl/cgs_fsm.sv =====
// Crossing state machine: entry actions, transitions and exit actions per tick.
module cgs_fsm (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  cgs_pkg::req_type               req,
   input  logic [cgs_pkg::DelayWidth-1:0] init_delay,
   output cgs_pkg::rsp_type               rsp
);

   typedef enum logic [2:0] {
      MODE_INIT     = 3'd0,
      MODE_OPENED   = 3'd1,
      MODE_OPEN2    = 3'd2,
      MODE_TO_OPEN  = 3'd3,
      MODE_CLOSED   = 3'd4,
      MODE_CLOSE2   = 3'd5,
      MODE_CLOSE3   = 3'd6,
      MODE_TO_CLOSE = 3'd7
   } mode_type;

   localparam logic [cgs_pkg::CountWidth-1:0] CountMax = '1;

   mode_type                         mode_ff, mode_in;
   logic                             entry_ff, entry_in;
   logic [cgs_pkg::CountWidth-1:0]   count_ff, count_in;
   logic [cgs_pkg::CountWidth-1:0]   count_base;
   logic                             moved;
   logic                             delay_done;

   // Restart the count on init entry, then advance with saturation
   always_comb begin
      count_base = (entry_ff && (mode_ff == MODE_INIT)) ? '0 : count_ff;
      count_in   = count_ff;
      if (mode_ff == MODE_INIT) begin
         count_in = (count_base != CountMax) ? count_base + 1'b1 : count_base;
      end else if (entry_ff && (mode_ff == MODE_INIT)) begin
         count_in = '0;
      end
      delay_done = cgs_pkg::CmpWidth'(count_in) >= cgs_pkg::CmpWidth'(init_delay);
   end

   // Evaluate one tick: later true condition wins
   always_comb begin
      rsp     = '0;
      mode_in = mode_ff;
      moved   = 1'b0;

      if (entry_ff) begin
         rsp.entered = 1'b1;
         case (mode_ff)
            MODE_INIT: begin
               rsp.led_color      = cgs_pkg::LedOrange;
               rsp.reinit_sensors = 1'b1;
            end
            MODE_OPENED: begin
               rsp.led_color  = cgs_pkg::LedGreen;
               rsp.entry_horn = cgs_pkg::HornConfirm;
            end
            MODE_TO_CLOSE: begin
               rsp.led_color    = cgs_pkg::LedOrange;
               rsp.gate_command = cgs_pkg::GateClose;
            end
            MODE_CLOSED: begin
               rsp.led_color  = cgs_pkg::LedRed;
               rsp.entry_horn = cgs_pkg::HornWarning;
            end
            MODE_TO_OPEN: begin
               rsp.led_color    = cgs_pkg::LedOrange;
               rsp.gate_command = cgs_pkg::GateOpen;
            end
            default: begin
               rsp.led_color = cgs_pkg::LedOrange;
            end
         endcase
      end

      case (mode_ff)
         MODE_INIT: begin
            if (delay_done) begin
               mode_in = MODE_OPENED;
               moved   = 1'b1;
            end
         end
         MODE_OPENED: begin
            if (req.switch_pushed) begin
               mode_in = MODE_OPEN2;
               moved   = 1'b1;
            end
            if (req.train_at_entry) begin
               mode_in = MODE_TO_CLOSE;
               moved   = 1'b1;
            end
         end
         MODE_OPEN2: begin
            if (!req.switch_pushed) begin
               mode_in = MODE_TO_CLOSE;
               moved   = 1'b1;
            end
         end
         MODE_TO_CLOSE: begin
            if (req.gate_is_closed) begin
               mode_in = MODE_CLOSED;
               moved   = 1'b1;
            end
         end
         MODE_CLOSED: begin
            if (req.switch_pushed) begin
               mode_in = MODE_CLOSE3;
               moved   = 1'b1;
            end
            if (req.train_in_crossing) begin
               mode_in = MODE_CLOSE2;
               moved   = 1'b1;
            end
         end
         MODE_CLOSE3: begin
            if (!req.switch_pushed) begin
               mode_in = MODE_TO_OPEN;
               moved   = 1'b1;
            end
         end
         MODE_CLOSE2: begin
            if (!req.train_in_crossing) begin
               mode_in = MODE_TO_OPEN;
               moved   = 1'b1;
            end
         end
         MODE_TO_OPEN: begin
            if (req.gate_is_opened) begin
               mode_in = MODE_OPENED;
               moved   = 1'b1;
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase

      // Exit actions of the state being left
      if (moved) begin
         if (mode_ff == MODE_INIT) begin
            rsp.calibrate = 1'b1;
         end else if (mode_ff == MODE_OPENED) begin
            rsp.exit_horn = cgs_pkg::PassAtA;
         end else if (mode_ff == MODE_TO_OPEN) begin
            rsp.exit_horn = cgs_pkg::PassAtB;
         end
      end

      entry_in     = moved;
      rsp.mode_now = mode_in;
   end

   // Hold state between ticks, advance on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_INIT;
         entry_ff <= 1'b1;
         count_ff <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         entry_ff <= entry_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/crossing_gate_sequencer_core.sv =====
// Top level of the crossing gate sequencer: channels, config port, result register.
//
// One request transaction is one control tick carrying the five sensor levels.
// Every accepted tick yields exactly one response transaction: the mode after
// the tick, an entry flag, the lamp color, the sensor reinit and calibrate
// pulses, the gate command and the entry and exit horn codes.
// The response is registered: it appears in the cycle after acceptance.
// Throughput is one tick per cycle unless a held response is stalled, set by the
// state update in the state machine and the one result register that follows it.
// The request side stalls only while a response is held and rsp_stall is high;
// a held response keeps its value until it is taken.
// The init delay register (byte address 0) sets how many ticks the block
// stays in init before the crossing opens; write it only while idle.
// Synchronous active-high reset puts the machine in init with entry actions
// pending, clears the delay count and loads the delay register with 3000.
module crossing_gate_sequencer_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  cgs_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output cgs_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cgs_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [cgs_pkg::CsrDataWidth-1:0] pwdata,
   output logic [cgs_pkg::CsrDataWidth-1:0] prdata,
   output logic                             pready
);

   logic [cgs_pkg::DelayWidth-1:0] init_delay;
   logic                           req_take;
   cgs_pkg::rsp_type               step_rsp;
   logic                           rsp_valid_ff, rsp_valid_in;
   cgs_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   cgs_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .init_delay (init_delay)
   );

   // Accept while the result register is empty or being drained
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   cgs_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (req_take),
      .req        (req_data),
      .init_delay (init_delay),
      .rsp        (step_rsp)
   );

   // Load a new result on accept, drop the old one once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/crossing_gate_sequencer_core_tb.sv =====
// Self-checking testbench for the crossing gate sequencer core.
`timescale 1ns / 100ps

module crossing_gate_sequencer_core_tb;
   import cgs_pkg::*;

   // Machine states as reported in mode_now
   localparam logic [2:0] ModeInit    = 3'd0;
   localparam logic [2:0] ModeOpened  = 3'd1;
   localparam logic [2:0] ModeOpen2   = 3'd2;
   localparam logic [2:0] ModeToOpen  = 3'd3;
   localparam logic [2:0] ModeClosed  = 3'd4;
   localparam logic [2:0] ModeClose2  = 3'd5;
   localparam logic [2:0] ModeClose3  = 3'd6;
   localparam logic [2:0] ModeToClose = 3'd7;

   // Register addresses: the delay register and an unused slot
   localparam logic [CsrAddrWidth-1:0] DelayAddr = {CsrIdxInitDelay, 2'b00};
   localparam logic [CsrAddrWidth-1:0] SpareAddr = {~CsrIdxInitDelay, 2'b00};

   localparam int HoldCycles = 200;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [CsrDataWidth-1:0] pwdata = '0;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   crossing_gate_sequencer_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Ticks waiting to be sent and steps waiting to come back
   req_type pending_ticks[$];
   rsp_type expected_steps[$];

   // Predicted machine state and register
   logic [2:0]            gate_mode = ModeInit;
   logic                  entry_due = 1'b1;
   logic [CountWidth-1:0] init_ticks = '0;
   logic [DelayWidth-1:0] init_delay = DelayReset;

   int  mismatch_count = 0;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic quiet_sides = 1'b0;
   int  send_gap = 0;
   int  take_gap = 0;
   int  hold_left = 0;
   int  holds_asked = 0;
   int  holds_served = 0;

   // Advance the predicted machine by one tick and return its step
   function automatic rsp_type step_crossing(req_type t);
      rsp_type    s;
      logic [2:0] nxt;
      logic       moved;
      s = '0;
      nxt = gate_mode;
      moved = 1'b0;

      // Entry actions of a freshly entered state
      if (entry_due) begin
         entry_due = 1'b0;
         s.entered = 1'b1;
         case (gate_mode)
            ModeInit: begin
               s.led_color = LedOrange;
               s.reinit_sensors = 1'b1;
               init_ticks = '0;
            end
            ModeOpened: begin
               s.led_color = LedGreen;
               s.entry_horn = HornConfirm;
            end
            ModeToClose: begin
               s.led_color = LedOrange;
               s.gate_command = GateClose;
            end
            ModeClosed: begin
               s.led_color = LedRed;
               s.entry_horn = HornWarning;
            end
            ModeToOpen: begin
               s.led_color = LedOrange;
               s.gate_command = GateOpen;
            end
            default: begin
               s.led_color = LedOrange;
            end
         endcase
      end

      // Transitions: the later true condition wins
      case (gate_mode)
         ModeInit: begin
            if (init_ticks != '1) init_ticks = init_ticks + 1'b1;
            if (init_ticks >= init_delay) begin
               nxt = ModeOpened;
               moved = 1'b1;
            end
         end
         ModeOpened: begin
            if (t.switch_pushed) begin
               nxt = ModeOpen2;
               moved = 1'b1;
            end
            if (t.train_at_entry) begin
               nxt = ModeToClose;
               moved = 1'b1;
            end
         end
         ModeOpen2: begin
            if (!t.switch_pushed) begin
               nxt = ModeToClose;
               moved = 1'b1;
            end
         end
         ModeToClose: begin
            if (t.gate_is_closed) begin
               nxt = ModeClosed;
               moved = 1'b1;
            end
         end
         ModeClosed: begin
            if (t.switch_pushed) begin
               nxt = ModeClose3;
               moved = 1'b1;
            end
            if (t.train_in_crossing) begin
               nxt = ModeClose2;
               moved = 1'b1;
            end
         end
         ModeClose3: begin
            if (!t.switch_pushed) begin
               nxt = ModeToOpen;
               moved = 1'b1;
            end
         end
         ModeClose2: begin
            if (!t.train_in_crossing) begin
               nxt = ModeToOpen;
               moved = 1'b1;
            end
         end
         default: begin
            if (t.gate_is_opened) begin
               nxt = ModeOpened;
               moved = 1'b1;
            end
         end
      endcase

      // Exit actions of the state being left
      if (moved) begin
         entry_due = 1'b1;
         if (gate_mode == ModeInit) s.calibrate = 1'b1;
         else if (gate_mode == ModeOpened) s.exit_horn = PassAtA;
         else if (gate_mode == ModeToOpen) s.exit_horn = PassAtB;
      end
      gate_mode = nxt;
      s.mode_now = nxt;
      return s;
   endfunction

   function automatic string describe_step(rsp_type s);
      return $sformatf({"mode=%0d entered=%b led=%0d reinit=%b gate=%0d ",
                        "ehorn=%0d xhorn=%0d cal=%b"},
         s.mode_now, s.entered, s.led_color, s.reinit_sensors, s.gate_command,
         s.entry_horn, s.exit_horn, s.calibrate);
   endfunction

   // Write a register, then read back the delay register and compare
   task automatic set_init_delay(input logic [CsrAddrWidth-1:0] addr,
                                 input logic [CsrDataWidth-1:0] value);
      logic [CsrDataWidth-1:0] readback;
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (addr == DelayAddr) init_delay = value[DelayWidth-1:0];
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      paddr <= DelayAddr;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      readback = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (readback !== CsrDataWidth'(init_delay)) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("delay readback mismatch: expected %0h got %0h", init_delay, readback);
      end
   endtask

   // Hold until every queued tick is sent and every step has come back
   task automatic wait_quiet();
      while (pending_ticks.size() != 0 || req_valid || expected_steps.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   // Predict on each accepted tick, check each accepted step
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) expected_steps.push_back(step_crossing(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_steps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected step: %s", describe_step(rsp_data));
            end else begin
               want = expected_steps.pop_front();
               if (rsp_data.mode_now !== want.mode_now
                   || rsp_data.entered !== want.entered
                   || rsp_data.led_color !== want.led_color
                   || rsp_data.reinit_sensors !== want.reinit_sensors
                   || rsp_data.gate_command !== want.gate_command
                   || rsp_data.entry_horn !== want.entry_horn
                   || rsp_data.exit_horn !== want.exit_horn
                   || rsp_data.calibrate !== want.calibrate) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("step mismatch: expected %s got %s",
                        describe_step(want), describe_step(rsp_data));
               end
            end
         end
      end
      req_fire <= !reset && req_valid && !req_stall;
      rsp_fire <= !reset && rsp_valid && !rsp_stall;
   end

   // Drive ticks, with a random gap drawn after each transaction
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (req_fire) send_gap = quiet_sides ? 0 : $urandom_range(16, 0);
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_ticks.size() > 0) begin
            req_data <= pending_ticks.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Take steps, stalling at random and for one long hold when asked
   always @(negedge clock) begin
      if (!reset) begin
         if (holds_served < holds_asked) begin
            hold_left = HoldCycles;
            holds_served++;
         end
         if (rsp_fire) take_gap = quiet_sides ? 0 : $urandom_range(16, 0);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus; tick bits read switch, at_a, occupied, closed, opened
   initial begin
      logic [4:0]              levels;
      logic [2:0]              pick;
      logic [CsrDataWidth-1:0] delay_value;
      levels = '0;
      pick = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Init state: extremes and each level alone
      pending_ticks.push_back(5'b00000);
      pending_ticks.push_back(5'b11111);
      pending_ticks.push_back(5'b10000);
      pending_ticks.push_back(5'b01000);
      pending_ticks.push_back(5'b00100);
      pending_ticks.push_back(5'b00010);
      pending_ticks.push_back(5'b00001);
      wait_quiet();

      // Largest delay, with upper data bits that the register drops
      set_init_delay(DelayAddr, '1);
      pending_ticks.push_back(5'b11111);
      pending_ticks.push_back(5'b01010);
      wait_quiet();

      // Ignored slot, then a delay reached two ticks from now
      set_init_delay(SpareAddr, 32'd1);
      set_init_delay(DelayAddr, CsrDataWidth'(init_ticks) + 2);
      pending_ticks.push_back(5'b11111);
      pending_ticks.push_back(5'b00000);

      // Walk the states opened, to_close, closed, close2, to_open
      pending_ticks.push_back(5'b11000);
      pending_ticks.push_back(5'b00000);
      pending_ticks.push_back(5'b00010);
      pending_ticks.push_back(5'b10100);
      pending_ticks.push_back(5'b00100);
      pending_ticks.push_back(5'b00000);
      pending_ticks.push_back(5'b00001);
      // Switch path: open2, to_close, closed, close3, to_open, opened
      pending_ticks.push_back(5'b10000);
      pending_ticks.push_back(5'b00000);
      pending_ticks.push_back(5'b00010);
      pending_ticks.push_back(5'b10000);
      pending_ticks.push_back(5'b00000);
      pending_ticks.push_back(5'b00001);
      wait_quiet();

      // Random phases, each preceded by a register setting
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: delay_value = '0;
            1: delay_value = 32'd1;
            2: delay_value = 32'h000F_FFFF;
            3: delay_value = 32'(DelayReset);
            default: delay_value = $urandom;
         endcase
         set_init_delay(DelayAddr, delay_value);
         quiet_sides = (phase == 3 || phase == 6);
         if (phase == 6) holds_asked++;
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(1, 0)) begin
               levels = 5'($urandom_range(31, 0));
            end else begin
               pick = 3'($urandom_range(4, 0));
               levels[pick] = ~levels[pick];
            end
            pending_ticks.push_back(levels);
         end
         wait_quiet();
      end

      quiet_sides = 1'b0;
      if (mismatch_count == 0 && expected_steps.size() == 0) begin
         $display("crossing_gate_sequencer_core verification clean");
      end else begin
         $display("crossing_gate_sequencer_core verification failed");
      end
      $finish;
   end

   // Timeout
   initial begin
      #2_000_000;
      $display("crossing_gate_sequencer_core verification failed");
      $finish;
   end

endmodule

// ===== crossing_gate_sequencer_core.f =====
rtl/cgs_pkg.sv
rtl/cgs_csr.sv
rtl/cgs_fsm.sv
rtl/crossing_gate_sequencer_core.sv
tb/crossing_gate_sequencer_core_tb.sv
